@@ rtl/core/zcss_pkg.sv @@
// ----------------------------------------------------------------------------
// zcss_pkg
// Shared types and constants for the zero-crossing symbol synchronizer.
// ----------------------------------------------------------------------------
`default_nettype none

package zcss_pkg;

   localparam int SAMPLE_WIDTH    = 16;
   localparam int BAUD_WIDTH      = 27;
   localparam int SRATE_WIDTH     = 28;
   localparam int PHASE_WIDTH     = 30;
   localparam int ACC_WIDTH       = PHASE_WIDTH + 1;
   localparam int CSR_INDEX_WIDTH = 1;
   localparam int CSR_DATA_WIDTH  = 32;

   localparam logic [BAUD_WIDTH-1:0]  BAUD_RESET  = BAUD_WIDTH'(9600);
   localparam logic [SRATE_WIDTH-1:0] SRATE_RESET = SRATE_WIDTH'(96000);
   localparam logic [PHASE_WIDTH-1:0] PHASE_MAX   = {PHASE_WIDTH{1'b1}};

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_BAUD_INC   = 1'b0,
      CSR_WRAP_LIMIT = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic [BAUD_WIDTH-1:0]  baud_inc;
      logic [SRATE_WIDTH-1:0] wrap_limit;
   } cfg_type;

   typedef struct packed {
      logic emit;
      logic bit_val;
   } sym_type;

endpackage

`default_nettype wire

@@ rtl/core/zero_crossing_symbol_sync.sv @@
// ----------------------------------------------------------------------------
// zero_crossing_symbol_sync
// Path: the sample register holds an accepted sample; its symbol is registered
// onto rsp_. Throughput: one sample per cycle; a symbol waiting on rsp_ holds
// the sample register, stalls req_. Add, compare, subtract are combinational.
// Reset: synchronous; rates return to 9600 / 96000, phase to 96000,
// previous sample to zero and the symbol request is raised.
// ----------------------------------------------------------------------------
`default_nettype none

module zero_crossing_symbol_sync (
   input  wire                                   clock,
   input  wire                                   reset,
   input  wire                                   req_valid,
   output logic                                  req_ready,
   input  wire  [zcss_pkg::SAMPLE_WIDTH-1:0]     req_sample,
   output logic                                  rsp_valid,
   input  wire                                   rsp_ready,
   output logic                                  rsp_bit_res,
   input  wire                                   csr_valid,
   output logic                                  csr_ready,
   input  wire  [zcss_pkg::CSR_INDEX_WIDTH-1:0]  csr_index,
   input  wire  [zcss_pkg::CSR_DATA_WIDTH-1:0]   csr_wdata
);

   zcss_pkg::cfg_type cfg;
   zcss_pkg::sym_type sym;

   logic                              in_valid_ff;
   logic                              in_valid_in;
   logic [zcss_pkg::SAMPLE_WIDTH-1:0] in_sample_ff;
   logic                              rsp_valid_ff;
   logic                              rsp_valid_in;
   logic                              rsp_bit_ff;
   logic                              advance;

   zcss_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .csr_ready (csr_ready),
      .cfg       (cfg)
   );

   zcss_phase u_phase (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .sample  (in_sample_ff),
      .cfg     (cfg),
      .sym     (sym)
   );

   assign advance     = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready   = !in_valid_ff || advance;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_bit_res = rsp_bit_ff;

   always_comb begin
      in_valid_in  = req_ready ? req_valid : in_valid_ff;
      rsp_valid_in = advance ? sym.emit : (rsp_valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_sample_ff <= req_sample;
      end
      if (advance && sym.emit) begin
         rsp_bit_ff <= sym.bit_val;
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !advance |=> in_valid_ff && $stable(in_sample_ff))
      else $error("held request lost");

   assert property (@(posedge clock) disable iff (reset)
      advance && sym.emit |=> rsp_valid_ff)
      else $error("symbol not presented");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ready |-> !advance)
      else $error("advance over a pending symbol");

endmodule

`default_nettype wire

@@ rtl/core/zcss_csr.sv @@
// ----------------------------------------------------------------------------
// zcss_csr
// Baud rate and sample rate configuration registers.
// ----------------------------------------------------------------------------
`default_nettype none

module zcss_csr (
   input  wire                                   clock,
   input  wire                                   reset,
   input  wire                                   csr_valid,
   input  wire  [zcss_pkg::CSR_INDEX_WIDTH-1:0]  csr_index,
   input  wire  [zcss_pkg::CSR_DATA_WIDTH-1:0]   csr_wdata,
   output logic                                  csr_ready,
   output zcss_pkg::cfg_type                     cfg
);

   zcss_pkg::cfg_type cfg_ff;
   zcss_pkg::cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (zcss_pkg::csr_index_type'(csr_index))
            zcss_pkg::CSR_BAUD_INC:
               cfg_in.baud_inc = csr_wdata[zcss_pkg::BAUD_WIDTH-1:0];
            zcss_pkg::CSR_WRAP_LIMIT:
               cfg_in.wrap_limit = csr_wdata[zcss_pkg::SRATE_WIDTH-1:0];
            default:
               cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.baud_inc   <= zcss_pkg::BAUD_RESET;
         cfg_ff.wrap_limit <= zcss_pkg::SRATE_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

`default_nettype wire

@@ rtl/core/zcss_phase.sv @@
// ----------------------------------------------------------------------------
// zcss_phase
// Zero-crossing detect, phase accumulator and symbol request state.
// ----------------------------------------------------------------------------
`default_nettype none

module zcss_phase (
   input  wire                                clock,
   input  wire                                reset,
   input  wire                                advance,
   input  wire  [zcss_pkg::SAMPLE_WIDTH-1:0]  sample,
   input  zcss_pkg::cfg_type                  cfg,
   output zcss_pkg::sym_type                  sym
);

   localparam int AW = zcss_pkg::ACC_WIDTH;
   localparam int MSB = zcss_pkg::SAMPLE_WIDTH - 1;

   logic [zcss_pkg::SAMPLE_WIDTH-1:0] prev_sample_ff;
   logic [zcss_pkg::SAMPLE_WIDTH-1:0] prev_sample_in;
   logic [zcss_pkg::PHASE_WIDTH-1:0]  phase_count_ff;
   logic [zcss_pkg::PHASE_WIDTH-1:0]  phase_count_in;
   logic                              request_ff;
   logic                              request_in;

   logic          crossing;
   logic          request_eff;
   logic          wrap;
   logic [AW-1:0] acc_base;
   logic [AW-1:0] acc_wrapped;
   logic [AW-1:0] acc_final;
   logic [AW-1:0] srate_ext;
   logic [AW-1:0] half_srate;

   always_comb begin
      crossing = (sample == '0) || (prev_sample_ff == '0) ||
                 (sample[MSB] != prev_sample_ff[MSB]);
      srate_ext  = AW'(cfg.wrap_limit);
      half_srate = AW'(cfg.wrap_limit >> 1);
      if (crossing) begin
         acc_base = AW'(cfg.baud_inc >> 1);
      end else begin
         acc_base = AW'(phase_count_ff) + AW'(cfg.baud_inc);
      end
      request_eff = crossing || request_ff;
      wrap        = (acc_base >= srate_ext);
      acc_wrapped = acc_base - srate_ext;
      acc_final   = wrap ? acc_wrapped : acc_base;
      sym.emit    = !wrap && request_eff && (acc_base >= half_srate);
      sym.bit_val = !sample[MSB];
   end

   always_comb begin
      prev_sample_in = prev_sample_ff;
      phase_count_in = phase_count_ff;
      request_in     = request_ff;
      if (advance) begin
         prev_sample_in = sample;
         request_in     = wrap || (request_eff && !sym.emit);
         if (acc_final > AW'(zcss_pkg::PHASE_MAX)) begin
            phase_count_in = zcss_pkg::PHASE_MAX;
         end else begin
            phase_count_in = acc_final[zcss_pkg::PHASE_WIDTH-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_sample_ff <= '0;
         phase_count_ff <= zcss_pkg::PHASE_WIDTH'(zcss_pkg::SRATE_RESET);
         request_ff     <= 1'b1;
      end else begin
         prev_sample_ff <= prev_sample_in;
         phase_count_ff <= phase_count_in;
         request_ff     <= request_in;
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      advance && sym.emit |=> !request_ff)
      else $error("request not cleared after symbol");

   assert property (@(posedge clock) disable iff (reset)
      advance && wrap |=> request_ff)
      else $error("request not raised on wrap");

   assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(phase_count_ff) && $stable(request_ff) &&
                   $stable(prev_sample_ff))
      else $error("state changed without an advancing request");

endmodule

`default_nettype wire

@@ dv/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for zero_crossing_symbol_sync. A clocked driver sends
// baseband samples from a queue that the stimulus sequence fills: a short
// directed run, then symbol-shaped streams with sign runs near the expected
// symbol length, mixed with noise, across several rate settings that include
// zero, maximum and out-of-range values. A clocked monitor keeps a
// cycle-free model of the phase accumulator, predicts the bit, if any, for
// each accepted request, and compares every result in order.
// ----------------------------------------------------------------------------
module tb_top;

   logic                                 clock      = 1'b0;
   logic                                 reset      = 1'b1;
   logic                                 req_valid  = 1'b0;
   logic                                 req_ready;
   logic [zcss_pkg::SAMPLE_WIDTH-1:0]    req_sample = '0;
   logic                                 rsp_valid;
   logic                                 rsp_ready  = 1'b0;
   logic                                 rsp_bit_res;
   logic                                 csr_valid  = 1'b0;
   logic                                 csr_ready;
   zcss_pkg::csr_index_type              csr_index  = zcss_pkg::CSR_BAUD_INC;
   logic [zcss_pkg::CSR_DATA_WIDTH-1:0]  csr_wdata  = '0;

   logic [zcss_pkg::SAMPLE_WIDTH-1:0]    sample_queue [$];
   logic                                 symbol_bits_due [$];
   logic                                 req_fire = 1'b0;
   int                                   samples_queued = 0;
   int                                   samples_taken = 0;
   int                                   mismatch_count = 0;
   int                                   snd_idle_pct = 0;
   int                                   rcv_idle_pct = 0;

   zcss_pkg::cfg_type                    cfg;
   logic [zcss_pkg::SAMPLE_WIDTH-1:0]    prev_smp;
   logic [zcss_pkg::PHASE_WIDTH-1:0]     phase_acc;
   logic                                 symbol_pending;

   zero_crossing_symbol_sync dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_sample  (req_sample),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_bit_res (rsp_bit_res),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata)
   );

   always #1 clock = ~clock;

   function automatic zcss_pkg::sym_type step_symbol_timing(
      input logic [zcss_pkg::SAMPLE_WIDTH-1:0] smp);
      zcss_pkg::sym_type sym;
      logic [31:0]       acc;
      logic              crossing;
      sym = '0;
      crossing = (smp == '0) || (prev_smp == '0) ||
                 (smp[zcss_pkg::SAMPLE_WIDTH-1] != prev_smp[zcss_pkg::SAMPLE_WIDTH-1]);
      if (crossing) begin
         acc = 32'(cfg.baud_inc >> 1);
         symbol_pending = 1'b1;
      end else begin
         acc = 32'(phase_acc) + 32'(cfg.baud_inc);
      end
      if (acc >= 32'(cfg.wrap_limit)) begin
         acc = acc - 32'(cfg.wrap_limit);
         symbol_pending = 1'b1;
      end else if (symbol_pending && acc >= 32'(cfg.wrap_limit >> 1)) begin
         sym.emit = 1'b1;
         sym.bit_val = ~smp[zcss_pkg::SAMPLE_WIDTH-1];
         symbol_pending = 1'b0;
      end
      if (acc > 32'(zcss_pkg::PHASE_MAX))
         acc = 32'(zcss_pkg::PHASE_MAX);
      phase_acc = acc[zcss_pkg::PHASE_WIDTH-1:0];
      prev_smp = smp;
      return sym;
   endfunction

   always @(negedge clock) begin
      if (!(req_valid && !req_fire)) begin
         if (sample_queue.size() != 0 && $urandom_range(99) >= snd_idle_pct) begin
            req_valid <= 1'b1;
            req_sample <= sample_queue.pop_front();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin
      rsp_ready <= ($urandom_range(99) >= rcv_idle_pct);
   end

   always @(posedge clock) begin : symbol_monitor
      zcss_pkg::sym_type sym;
      logic              due_bit;
      req_fire <= req_valid && req_ready;
      if (reset) begin
         cfg.baud_inc = zcss_pkg::BAUD_RESET;
         cfg.wrap_limit = zcss_pkg::SRATE_RESET;
         prev_smp = '0;
         phase_acc = zcss_pkg::PHASE_WIDTH'(zcss_pkg::SRATE_RESET);
         symbol_pending = 1'b1;
      end else begin
         if (csr_valid && csr_ready) begin
            if (csr_index == zcss_pkg::CSR_BAUD_INC)
               cfg.baud_inc = csr_wdata[zcss_pkg::BAUD_WIDTH-1:0];
            else
               cfg.wrap_limit = csr_wdata[zcss_pkg::SRATE_WIDTH-1:0];
         end
         if (req_valid && req_ready) begin
            sym = step_symbol_timing(req_sample);
            samples_taken++;
            if (sym.emit)
               symbol_bits_due.push_back(sym.bit_val);
         end
         if (rsp_valid && rsp_ready) begin
            if (symbol_bits_due.size() == 0) begin
               $error("bit_res: unexpected result, expected none, actual %0d", rsp_bit_res);
               mismatch_count++;
            end else begin
               due_bit = symbol_bits_due.pop_front();
               if (rsp_bit_res !== due_bit) begin
                  $error("bit_res mismatch: expected %0d, actual %0d", due_bit, rsp_bit_res);
                  mismatch_count++;
               end
            end
         end
      end
   end

   task automatic queue_sample(input logic [zcss_pkg::SAMPLE_WIDTH-1:0] smp);
      sample_queue.push_back(smp);
      samples_queued++;
   endtask

   task automatic wait_until_drained();
      do @(negedge clock);
      while (samples_taken != samples_queued || symbol_bits_due.size() != 0);
      repeat (8) @(negedge clock);
   endtask

   task automatic write_csr(input zcss_pkg::csr_index_type idx,
                            input logic [zcss_pkg::CSR_DATA_WIDTH-1:0] data);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock);
      while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic queue_symbol_stream(input int n_items, input int snd_pct, input int rcv_pct);
      int                                remaining;
      int                                span;
      int                                run_len;
      logic                              polarity;
      logic [zcss_pkg::SAMPLE_WIDTH-1:0] smp;
      @(posedge clock);
      snd_idle_pct = snd_pct;
      rcv_idle_pct = rcv_pct;
      remaining = n_items;
      while (remaining > 0) begin
         if ($urandom_range(99) < 85) begin
            if (cfg.baud_inc == '0 || cfg.wrap_limit == '0)
               span = $urandom_range(12, 1);
            else
               span = int'(cfg.wrap_limit / cfg.baud_inc);
            if (span > 16)
               span = 16;
            run_len = span + int'($urandom_range(2)) - 1;
            if (run_len < 1)
               run_len = 1;
            polarity = $urandom_range(1);
            for (int i = 0; i < run_len && remaining > 0; i++) begin
               if (polarity)
                  smp = ($urandom_range(7) == 0) ? 16'h7FFF : 16'($urandom_range(32767, 1));
               else
                  smp = ($urandom_range(7) == 0) ? 16'h8000 :
                        16'(0 - $urandom_range(32768, 1));
               queue_sample(smp);
               remaining--;
            end
         end else begin
            smp = ($urandom_range(4) == 0) ? '0 : 16'($urandom);
            queue_sample(smp);
            remaining--;
         end
      end
   endtask

   task automatic run_phase(input logic [zcss_pkg::CSR_DATA_WIDTH-1:0] baud_word,
                            input logic [zcss_pkg::CSR_DATA_WIDTH-1:0] srate_word,
                            input int n_items, input int snd_pct, input int rcv_pct);
      wait_until_drained();
      write_csr(zcss_pkg::CSR_BAUD_INC, baud_word);
      write_csr(zcss_pkg::CSR_WRAP_LIMIT, srate_word);
      queue_symbol_stream(n_items, snd_pct, rcv_pct);
   endtask

   initial begin
      logic [zcss_pkg::SAMPLE_WIDTH-1:0] directed [$] = '{
         16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF,
         16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000,
         16'h0000, 16'h0001, 16'hFFFF, 16'h0001, 16'h0000, 16'h0000, 16'h7FFF, 16'h8000
      };
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(posedge clock);
      snd_idle_pct = 34;
      rcv_idle_pct = 81;
      foreach (directed[i])
         queue_sample(directed[i]);
      queue_symbol_stream(130, 34, 81);

      run_phase(32'd12000, 32'd48000, 55, 34, 81);
      // hold off until every symbol is out, then resume
      wait_until_drained();
      queue_symbol_stream(55, 34, 81);
      run_phase(32'd100000000, 32'd200000000, 100, 34, 81);

      run_phase(32'hFFFF_FFFF, 32'hF000_0000, 60, 81, 34);
      run_phase(32'd1, 32'd1, 80, 81, 34);
      run_phase(32'h07FF_FFFF, 32'd1, 90, 81, 34);

      run_phase(32'h0400_0000, 32'h0FFF_FFFF, 110, 0, 0);
      run_phase(32'd0, 32'd96000, 50, 0, 0);
      run_phase(32'd9600, 32'd96000, 100, 0, 0);

      wait_until_drained();
      if (mismatch_count == 0)
         $display("tb_top: PASS");
      else
         $display("tb_top: FAIL");
      $finish;
   end

   initial begin
      #1_000_000;
      $display("tb_top: FAIL");
      $finish;
   end

endmodule
